// ===== rtl/core/bf3_pkg.sv =====
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared constants, payload types and codes of the 3x3 box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

   // geometry and sample size
   localparam int MAX_WIDTH     = 2048;
   localparam int HEIGHT_LIMIT  = 2048;
   localparam int PIXEL_BITS    = 16;
   localparam int FIELD_BITS    = 16;
   localparam int CFG_BITS      = 12;
   localparam int MIN_DIM       = 3;
   localparam int WIDTH_RESET   = 640;
   localparam int HEIGHT_RESET  = 480;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS    = COL_BITS + 1;
   localparam int ROW_BITS      = $clog2(HEIGHT_LIMIT);
   localparam int HEIGHT_BITS   = ROW_BITS + 1;

   // window sum and divide by nine: floor(x / 9) == (x * RECIP_MUL) >> RECIP_SHIFT
   // for every x below 2**SUM_BITS, since RECIP_MUL * 9 exceeds 2**RECIP_SHIFT by 8
   localparam int SUM_BITS      = PIXEL_BITS + 4;
   localparam int ROUND_BIAS    = 4;
   localparam int RECIP_SHIFT   = SUM_BITS + 4;
   localparam int RECIP_BITS    = RECIP_SHIFT - 3;
   localparam int PROD_BITS     = SUM_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_MUL = RECIP_BITS'((2**RECIP_SHIFT + 8) / 9);

   // queue between front and back
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_BITS = QUEUE_PTR_BITS + 1;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } bf3_csr_index_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pixel;
      logic                  frame_start;
   } bf3_req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] mean_value;
      logic                  row_end;
      logic                  frame_end;
   } bf3_rsp_type;

   // one classified pixel with its column from the two line stores
   typedef struct packed {
      logic [PIXEL_BITS-1:0] up;
      logic [PIXEL_BITS-1:0] mid;
      logic [PIXEL_BITS-1:0] px;
      logic                  emit;
      logic                  last_col;
      logic                  last_row;
   } bf3_item_type;

endpackage

// ===== rtl/core/bf3_front.sv =====
// ----------------------------------------------------------------------------
// bf3_front
// Geometry registers, raster counters and the two line stores. Classifies
// each pixel beat and hands it with its column of three pixels to the queue.
// ----------------------------------------------------------------------------
module bf3_front import bf3_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bf3_req_type                 req_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CFG_BITS-1:0]         csr_data,
   input  logic [QUEUE_LEVEL_BITS-1:0] queue_level,
   output logic                        item_valid,
   output bf3_item_type                item
);

   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;

   logic [PIXEL_BITS-1:0]  upper_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0]  middle_mem [MAX_WIDTH];

   // read stage
   logic                   f1_valid_ff;
   logic [COL_BITS-1:0]    f1_col_ff;
   logic [PIXEL_BITS-1:0]  f1_px_ff;
   logic                   f1_emit_ff, f1_last_col_ff, f1_last_row_ff;
   logic [PIXEL_BITS-1:0]  upper_rd_ff, middle_rd_ff;
   logic                   fwd_ff;
   logic [PIXEL_BITS-1:0]  fwd_up_ff, fwd_mid_ff;

   logic                   accept;
   logic [COL_BITS-1:0]    col_base, col_cur;
   logic [ROW_BITS-1:0]    row_base, row_cur;
   logic [HEIGHT_BITS-1:0] row_step, row_inc;
   logic [WIDTH_BITS-1:0]  col_inc;
   logic                   col_wrap;
   logic [PIXEL_BITS-1:0]  px_cur, up_eff, mid_eff;

   assign csr_ready = 1'b1;

   // hold back a beat unless the queue has room for it and the one in flight
   assign req_ready = (QUEUE_LEVEL_BITS'(queue_level) + QUEUE_LEVEL_BITS'(f1_valid_ff))
                      < QUEUE_LEVEL_BITS'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (csr_data < CFG_BITS'(MIN_DIM)) begin
                  width_in = WIDTH_BITS'(MIN_DIM);
               end else if (int'(csr_data) > MAX_WIDTH) begin
                  width_in = WIDTH_BITS'(MAX_WIDTH);
               end else begin
                  width_in = WIDTH_BITS'(csr_data);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (csr_data < CFG_BITS'(MIN_DIM)) begin
                  height_in = HEIGHT_BITS'(MIN_DIM);
               end else if (int'(csr_data) > HEIGHT_LIMIT) begin
                  height_in = HEIGHT_BITS'(HEIGHT_LIMIT);
               end else begin
                  height_in = HEIGHT_BITS'(csr_data);
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // position of the incoming pixel, after a frame start or a shrunk geometry
   always_comb begin
      px_cur   = req_payload.pixel[PIXEL_BITS-1:0];
      col_base = req_payload.frame_start ? '0 : col_ff;
      row_base = req_payload.frame_start ? '0 : row_ff;
      col_wrap = WIDTH_BITS'(col_base) >= width_ff;
      col_cur  = col_wrap ? '0 : col_base;
      row_step = HEIGHT_BITS'(row_base) + HEIGHT_BITS'(col_wrap);
      row_cur  = (row_step >= height_ff) ? '0 : row_step[ROW_BITS-1:0];

      col_inc  = WIDTH_BITS'(col_cur) + WIDTH_BITS'(1);
      row_inc  = HEIGHT_BITS'(row_cur) + HEIGHT_BITS'(1);
      if (col_inc >= width_ff) begin
         col_in = '0;
         row_in = (row_inc >= height_ff) ? '0 : row_inc[ROW_BITS-1:0];
      end else begin
         col_in = col_inc[COL_BITS-1:0];
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_BITS'(WIDTH_RESET);
         height_ff   <= HEIGHT_BITS'(HEIGHT_RESET);
         col_ff      <= '0;
         row_ff      <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         f1_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // the pixel one beat ahead wrote the same column while this one was read: forward
   assign up_eff  = fwd_ff ? fwd_up_ff  : upper_rd_ff;
   assign mid_eff = fwd_ff ? fwd_mid_ff : middle_rd_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         upper_rd_ff    <= upper_mem[col_cur];
         middle_rd_ff   <= middle_mem[col_cur];
         f1_col_ff      <= col_cur;
         f1_px_ff       <= px_cur;
         f1_emit_ff     <= (row_cur >= ROW_BITS'(2)) && (col_cur >= COL_BITS'(2));
         f1_last_col_ff <= WIDTH_BITS'(col_cur) == (width_ff - WIDTH_BITS'(1));
         f1_last_row_ff <= HEIGHT_BITS'(row_cur) == (height_ff - HEIGHT_BITS'(1));
         fwd_ff         <= f1_valid_ff && (f1_col_ff == col_cur);
         fwd_up_ff      <= mid_eff;
         fwd_mid_ff     <= f1_px_ff;
      end
      if (f1_valid_ff) begin
         upper_mem[f1_col_ff]  <= mid_eff;
         middle_mem[f1_col_ff] <= f1_px_ff;
      end
   end

   assign item_valid    = f1_valid_ff;
   assign item.up       = up_eff;
   assign item.mid      = mid_eff;
   assign item.px       = f1_px_ff;
   assign item.emit     = f1_emit_ff;
   assign item.last_col = f1_last_col_ff;
   assign item.last_row = f1_last_row_ff;

endmodule

// ===== rtl/core/bf3_queue.sv =====
// ----------------------------------------------------------------------------
// bf3_queue
// Short first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module bf3_queue import bf3_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bf3_item_type                push_item,
   input  logic                        pop,
   output logic                        head_valid,
   output bf3_item_type                head_item,
   output logic [QUEUE_LEVEL_BITS-1:0] level
);

   bf3_item_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_LEVEL_BITS-1:0] level_ff, level_in;

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + QUEUE_LEVEL_BITS'(1);
      end else if (pop && !push) begin
         level_in = level_ff - QUEUE_LEVEL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = level_ff != '0;
   assign head_item  = entry_ff[rd_ptr_ff];
   assign level      = level_ff;

endmodule

// ===== rtl/core/bf3_back.sv =====
// ----------------------------------------------------------------------------
// bf3_back
// Window column sums, rounded divide by nine and the result register.
// ----------------------------------------------------------------------------
module bf3_back import bf3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  bf3_item_type head_item,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output bf3_rsp_type  rsp_payload
);

   // sums of the two previous window columns
   logic [SUM_BITS-1:0]  col_sum_ff;
   logic [SUM_BITS-1:0]  pair_sum_ff;

   logic                 b1_valid_ff;
   logic [SUM_BITS-1:0]  b1_total_ff;
   logic                 b1_row_end_ff, b1_frame_end_ff;

   logic                 b2_valid_ff;
   logic [PROD_BITS-1:0] b2_prod_ff;
   logic                 b2_row_end_ff, b2_frame_end_ff;

   logic                 rsp_valid_ff;
   bf3_rsp_type          rsp_ff;

   logic [SUM_BITS-1:0]  col_sum_in, total_in;
   logic                 rsp_load, b2_load, b1_load;

   assign rsp_load = !rsp_valid_ff || rsp_ready;
   assign b2_load  = !b2_valid_ff || rsp_load;
   assign b1_load  = !b1_valid_ff || b2_load;

   // a border pixel only moves the window, so it never waits on the pipe
   assign pop = head_valid && (!head_item.emit || b1_load);

   assign col_sum_in = SUM_BITS'(head_item.up) + SUM_BITS'(head_item.mid)
                     + SUM_BITS'(head_item.px);
   assign total_in   = col_sum_in + pair_sum_ff + SUM_BITS'(ROUND_BIAS);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_sum_ff   <= '0;
         pair_sum_ff  <= '0;
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            col_sum_ff  <= col_sum_in;
            pair_sum_ff <= col_sum_ff + col_sum_in;
         end
         if (b1_load) begin
            b1_valid_ff <= pop && head_item.emit;
         end
         if (b2_load) begin
            b2_valid_ff <= b1_valid_ff;
         end
         if (rsp_load) begin
            rsp_valid_ff <= b2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b1_load) begin
         b1_total_ff     <= total_in;
         b1_row_end_ff   <= head_item.last_col;
         b1_frame_end_ff <= head_item.last_col && head_item.last_row;
      end
      if (b2_load) begin
         b2_prod_ff      <= PROD_BITS'(b1_total_ff) * PROD_BITS'(RECIP_MUL);
         b2_row_end_ff   <= b1_row_end_ff;
         b2_frame_end_ff <= b1_frame_end_ff;
      end
      if (rsp_load) begin
         rsp_ff.mean_value <= FIELD_BITS'(b2_prod_ff[RECIP_SHIFT +: PIXEL_BITS]);
         rsp_ff.row_end    <= b2_row_end_ff;
         rsp_ff.frame_end  <= b2_frame_end_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/box_filter_3x3_mean.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_mean
// 3x3 rounded mean over a raster stream of grey pixels.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock in row order while req_ready is high, a rate
// set by the single read and single write port of each line store. For each
// pixel that completes a 3x3 window inside the frame, it returns the window's
// floor((sum + 4) / 9); border pixels give no result. A result passes the line
// store read, queue, column sum, multiply and result register in order. A
// four-slot queue between the line stores and the arithmetic lets the input
// keep flowing while a result waits on rsp_ready. Width and height are clamped
// to their legal range on write; the user must change them only while the
// block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module box_filter_3x3_mean import bf3_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bf3_req_type               req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bf3_rsp_type               rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

   logic                        item_valid;
   bf3_item_type                item;
   logic                        pop;
   logic                        head_valid;
   bf3_item_type                head_item;
   logic [QUEUE_LEVEL_BITS-1:0] queue_level;

   bf3_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_level (queue_level),
      .item_valid  (item_valid),
      .item        (item)
   );

   bf3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (item_valid),
      .push_item  (item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .level      (queue_level)
   );

   bf3_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      item_valid |-> (queue_level < QUEUE_LEVEL_BITS'(QUEUE_DEPTH)))
      else $error("queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.frame_end) |-> rsp_payload.row_end)
      else $error("frame end without row end");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> (!rsp_valid && queue_level == '0))
      else $error("result or queued beat right after reset");

endmodule
